/* hw/rtl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, constants and helpers for the periodic timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    // table geometry
    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // field widths
    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int WAIT_W   = 10;

    localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 16'd16;
    localparam logic [WAIT_W-1:0]   IDLE_WAIT      = 10'd100;
    localparam logic [WAIT_W-1:0]   MAX_WAIT       = 10'd1000;
    localparam logic [WAIT_W-1:0]   MIN_WAIT       = 10'd1;

    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_CLEARED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_FIRED     = 3'd4,
        ST_SUMMARY   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [PERIOD_W-1:0] interval_ms;
        logic [ID_W-1:0]     target_ident;
    } cmd_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_ident;
        logic [2:0]        status;
        logic [WAIT_W-1:0] wait_ms;
        logic [4:0]        active_count;
        logic              last_result;
    } rsp_item_t;

    // one table entry as kept in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [TIME_W-1:0]   deadline;
        logic [PERIOD_W-1:0] period;
    } slot_t;

    // distance to a deadline, clamped; past deadlines give the minimum
    function automatic logic [WAIT_W-1:0] clamp_wait(input logic [TIME_W-1:0] d);
        logic [WAIT_W-1:0] w;
        if (d[TIME_W-1] || d == '0)
            w = MIN_WAIT;
        else if (d > TIME_W'(MAX_WAIT))
            w = MAX_WAIT;
        else
            w = d[WAIT_W-1:0];
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timers with a millisecond time base, fire and summary beats.
// ----------------------------------------------------------------------------
// Each schedule, clear or tick beat walks the whole slot memory, one slot a
// cycle, through a single-port-read, single-port-write memory with a
// registered read, then settles the table in a finish state. Schedule and
// clear then offer their single response beat. A tick rewrites due deadlines
// during that walk, then walks the slots a second time to send one fired beat
// per due timer in slot order, reading each slot and, for a fired slot,
// waiting for the output to take its beat, followed by a summary beat.
// Every beat of a command carries the post-command wait and active count;
// the last beat has last_result set. Command code three is taken and dropped
// with no response. Valid bits sit in flops cleared by reset, so no clearing
// pass is needed after reset.
`default_nettype none

module periodic_timer_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire ptt_pkg::cmd_item_t  cmd_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output ptt_pkg::rsp_item_t       rsp_data
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_OUT
    } state_t;

    // slot memory, contents meaningful only where the valid bit is set
    slot_t slot_mem [NUM_TIMERS];
    slot_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;

    // control state
    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic [ID_W-1:0]       next_ident_reg, next_ident_next;
    logic [NUM_TIMERS-1:0] valid_reg, valid_next;
    logic [NUM_TIMERS-1:0] fire_reg, fire_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  issuing_reg, issuing_next;
    logic [IDX_W-1:0]      proc_idx_reg, proc_idx_next;
    logic                  proc_ok_reg, proc_ok_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  any_reg, any_next;
    logic [IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // per-command payload
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [ID_W-1:0]       target_reg, target_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [ID_W-1:0]       after_reg, after_next;
    logic [WAIT_W-1:0]     acc_reg, acc_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next;
    logic [ID_W-1:0]       res_ident_reg, res_ident_next;
    status_t               res_status_reg, res_status_next;
    rsp_item_t             rsp_data_reg, rsp_data_next;

    // slot under inspection during the walk
    logic              pv;
    logic [TIME_W-1:0] age;
    logic              due;
    logic [TIME_W-1:0] rearm_dl;
    logic [TIME_W-1:0] post_dl;
    logic [WAIT_W-1:0] slot_w;
    logic [ID_W-1:0]   match_id;
    logic              hit;
    logic              contrib;
    logic [WAIT_W-1:0] acc_min;
    logic [WAIT_W-1:0] base_wait;
    logic [WAIT_W-1:0] new_w;
    logic [IDX_W-1:0]  sched_idx;
    logic              rsp_free;
    logic              rsp_load;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        pv       = valid_reg[proc_idx_reg];
        age      = now_reg - rd_data_reg.deadline;
        due      = pv && !age[TIME_W-1];
        rearm_dl = now_reg + TIME_W'(rd_data_reg.period);
        post_dl  = due ? rearm_dl : rd_data_reg.deadline;
        slot_w   = clamp_wait(post_dl - now_reg);
        match_id = (cmd_reg == CMD_SCHEDULE) ? id_reg : target_reg;
        hit      = pv && !found_reg && (rd_data_reg.ident == match_id) &&
                   ((cmd_reg == CMD_SCHEDULE) || (target_reg != '0));
        // a slot being replaced or freed drops out of the minimum
        contrib  = pv && !(hit && (cmd_reg != CMD_TICK));
        acc_min  = (!any_reg || slot_w < acc_reg) ? slot_w : acc_reg;
        base_wait = any_reg ? acc_reg : IDLE_WAIT;
        new_w     = clamp_wait(TIME_W'(period_reg));
        sched_idx = found_reg ? hit_idx_reg : free_idx_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        next_ident_next = next_ident_reg;
        valid_next      = valid_reg;
        fire_next       = fire_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        issuing_next    = issuing_reg;
        proc_idx_next   = proc_idx_reg;
        proc_ok_next    = proc_ok_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        any_next        = any_reg;
        emit_idx_next   = emit_idx_reg;
        period_next     = period_reg;
        target_next     = target_reg;
        id_next         = id_reg;
        after_next      = after_reg;
        acc_next        = acc_reg;
        wait_next       = wait_reg;
        res_ident_next  = res_ident_reg;
        res_status_next = res_status_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_load        = 1'b0;
        rd_addr         = rd_idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = proc_idx_reg;
        mem_wdata       = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd_t'(cmd_data.command);
                    target_next = cmd_data.target_ident;
                    period_next = (cmd_data.interval_ms == '0) ? DEFAULT_PERIOD
                                                               : cmd_data.interval_ms;
                    // identifier zero is skipped
                    if (next_ident_reg == '0)
                    begin
                        id_next    = ID_W'(1);
                        after_next = ID_W'(2);
                    end
                    else
                    begin
                        id_next    = next_ident_reg;
                        after_next = next_ident_reg + ID_W'(1);
                    end
                    if (cmd_data.command == CMD_TICK)
                        now_next = now_reg + TIME_W'(1);
                    if (cmd_data.command != CMD_NOP)
                    begin
                        state_next      = S_SCAN;
                        rd_idx_next     = '0;
                        issuing_next    = 1'b1;
                        proc_ok_next    = 1'b0;
                        found_next      = 1'b0;
                        free_found_next = 1'b0;
                        any_next        = 1'b0;
                        fire_next       = '0;
                    end
                end
            end

            S_SCAN:
            begin
                proc_idx_next = rd_idx_reg;
                proc_ok_next  = issuing_reg;
                if (issuing_reg)
                begin
                    if (rd_idx_reg == LAST_IDX)
                        issuing_next = 1'b0;
                    else
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
                if (proc_ok_reg)
                begin
                    if (contrib)
                    begin
                        acc_next = acc_min;
                        any_next = 1'b1;
                    end
                    if (cmd_reg == CMD_TICK)
                    begin
                        if (due)
                        begin
                            mem_we                  = 1'b1;
                            mem_wdata.deadline      = rearm_dl;
                            fire_next[proc_idx_reg] = 1'b1;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            found_next   = 1'b1;
                            hit_idx_next = proc_idx_reg;
                        end
                        if ((cmd_reg == CMD_SCHEDULE) && !pv && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = proc_idx_reg;
                        end
                    end
                    if (proc_idx_reg == LAST_IDX)
                        state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                wait_next  = base_wait;
                state_next = S_OUT;
                unique case (cmd_reg)
                    CMD_SCHEDULE:
                    begin
                        if (found_reg || free_found_reg)
                        begin
                            mem_we             = 1'b1;
                            mem_waddr          = sched_idx;
                            mem_wdata.ident    = id_reg;
                            mem_wdata.deadline = now_reg + TIME_W'(period_reg);
                            mem_wdata.period   = period_reg;
                            valid_next[sched_idx] = 1'b1;
                            next_ident_next    = after_reg;
                            if (!found_reg)
                                count_next = count_reg + CNT_W'(1);
                            wait_next       = (!any_reg || new_w < acc_reg) ? new_w : acc_reg;
                            res_ident_next  = id_reg;
                            res_status_next = ST_SCHEDULED;
                        end
                        else
                        begin
                            res_ident_next  = '0;
                            res_status_next = ST_FULL;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        if (found_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next      = count_reg - CNT_W'(1);
                            res_ident_next  = target_reg;
                            res_status_next = ST_CLEARED;
                        end
                        else
                        begin
                            res_ident_next  = '0;
                            res_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_TICK:
                    begin
                        res_ident_next  = '0;
                        res_status_next = ST_SUMMARY;
                        emit_idx_next   = '0;
                        state_next      = S_EMIT_RD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_EMIT_RD:
            begin
                rd_addr = emit_idx_reg;
                if (fire_reg[emit_idx_reg])
                    state_next = S_EMIT_WAIT;
                else if (emit_idx_reg == LAST_IDX)
                    state_next = S_OUT;
                else
                    emit_idx_next = emit_idx_reg + IDX_W'(1);
            end

            S_EMIT_WAIT:
            begin
                // hold the address so the read data stays put under backpressure
                rd_addr = emit_idx_reg;
                if (rsp_free)
                begin
                    rsp_load                   = 1'b1;
                    rsp_data_next.result_ident = rd_data_reg.ident;
                    rsp_data_next.status       = ST_FIRED;
                    rsp_data_next.wait_ms      = wait_reg;
                    rsp_data_next.active_count = 5'(count_reg);
                    rsp_data_next.last_result  = 1'b0;
                    if (emit_idx_reg == LAST_IDX)
                        state_next = S_OUT;
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                        state_next    = S_EMIT_RD;
                    end
                end
            end

            S_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_load                   = 1'b1;
                    rsp_data_next.result_ident = res_ident_reg;
                    rsp_data_next.status       = res_status_reg;
                    rsp_data_next.wait_ms      = wait_reg;
                    rsp_data_next.active_count = 5'(count_reg);
                    rsp_data_next.last_result  = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= slot_mem[rd_addr];
    end

    // control state and the registered response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_NOP;
            now_reg        <= '0;
            next_ident_reg <= ID_W'(1);
            valid_reg      <= '0;
            fire_reg       <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            issuing_reg    <= 1'b0;
            proc_idx_reg   <= '0;
            proc_ok_reg    <= 1'b0;
            found_reg      <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            any_reg        <= 1'b0;
            emit_idx_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            now_reg        <= now_next;
            next_ident_reg <= next_ident_next;
            valid_reg      <= valid_next;
            fire_reg       <= fire_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            issuing_reg    <= issuing_next;
            proc_idx_reg   <= proc_idx_next;
            proc_ok_reg    <= proc_ok_next;
            found_reg      <= found_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            any_reg        <= any_next;
            emit_idx_reg   <= emit_idx_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        period_reg     <= period_next;
        target_reg     <= target_next;
        id_reg         <= id_next;
        after_reg      <= after_next;
        acc_reg        <= acc_next;
        wait_reg       <= wait_next;
        res_ident_reg  <= res_ident_next;
        res_status_reg <= res_status_next;
        rsp_data_reg   <= rsp_data_next;
    end

    // running count matches the valid bits between commands
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg == CNT_W'($countones(valid_reg))))
        else $error("active count out of step with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_TIMERS))
        else $error("active count above table size");

    // a fired beat is only sent for a slot marked due
    a_emit_due_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_WAIT) |-> fire_reg[emit_idx_reg])
        else $error("fire beat for a slot that was not due");

    // the last beat of a command returns the block to idle
    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && rsp_data_next.last_result) |=> (state_reg == S_IDLE))
        else $error("last beat sent without ending the command");

endmodule

`default_nettype wire
